/* hdl/bfse_pkg.sv */
// ----------------------------------------------------------------------------
// bfse_pkg - bit field store engine shared definitions
// Operation codes, field size width and the control word for the shift unit.
// ----------------------------------------------------------------------------
package bfse_pkg;

    localparam int OP_W    = 3;
    localparam int FSIZE_W = 6;   // clamped field size, 0..32

    localparam logic [OP_W-1:0] OP_EXT_SIGNED   = 3'd0;
    localparam logic [OP_W-1:0] OP_EXT_UNSIGNED = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT       = 3'd2;
    localparam logic [OP_W-1:0] OP_BIT_SET      = 3'd3;
    localparam logic [OP_W-1:0] OP_BIT_CLEAR    = 3'd4;

    // control word handed to the shift/merge unit
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [2:0]         offset;   // bit offset inside the first byte
        logic [FSIZE_W-1:0] size;     // effective size (1 for bit ops)
    } unit_ctl_t;

endpackage

/* hdl/bit_field_store_engine_top.sv */
// ----------------------------------------------------------------------------
// bit_field_store_engine_top - bit field store engine
// Steps: a request touching N bytes (N = ceil((pos%8 + size)/8), at most
//   5) reads them, then extracts; inserts and bit ops (N = 1) also write
//   them back. Zero size, bad op or out of range answer at once.
// Throughput: one word at a time; the single RAM port (one byte per cycle)
//   and the shared shift unit set the pace. busy is high until done.
// Reset: rst_n clears control, then a clearing pass zeroes the store, one
//   byte per cycle, with busy high. Results cannot stall.
// ----------------------------------------------------------------------------
module bit_field_store_engine_top
    import bfse_pkg::*;
#(
    parameter int STORE_BYTES    = 1024,
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // request word
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [12:0] field_pos,
    input  logic [7:0]  field_size,
    input  logic [31:0] insert_value,
    // result word, valid for the single cycle done is high
    output logic        done,
    output logic [31:0] field_value,
    output logic        old_bit,
    output logic        out_of_range
);

    localparam int AW         = $clog2(STORE_BYTES);
    localparam int TOTAL_BITS = STORE_BYTES * 8;
    localparam int EW         = ($clog2(TOTAL_BITS + 1) > 14) ? $clog2(TOTAL_BITS + 1) : 14;
    // worst case span: offset 7 plus a full field
    localparam int WIN_BYTES  = (MAX_FIELD_BITS + 14) / 8;
    localparam int CW         = $clog2(WIN_BYTES + 1);
    localparam int BW         = $clog2(WIN_BYTES);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_CALC  = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    // done is a registered strobe, so no state of its own is needed

    state_t                       state_reg, state_next;
    logic [AW-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [CW-1:0]                nb_reg, nb_next;
    logic [AW-1:0]                base_reg, base_next;
    unit_ctl_t                    ctl_reg, ctl_next;
    logic [31:0]                  ival_reg, ival_next;
    logic [WIN_BYTES-1:0][7:0]    win_reg, win_next;
    logic                         done_reg, done_next;
    logic [31:0]                  fval_reg, fval_next;
    logic                         old_reg, old_next;
    logic                         oor_reg, oor_next;

    // request decode
    logic [FSIZE_W-1:0]           clamp_size;
    logic [FSIZE_W-1:0]           eff_size;
    logic [EW-1:0]                end_pos;
    logic                         req_oor;
    logic [6:0]                   span;
    logic [CW-1:0]                req_nb;
    logic                         accept;

    // RAM port
    logic                         ram_we;
    logic [AW-1:0]                ram_addr;
    logic [7:0]                   ram_wdata;
    logic [7:0]                   ram_rdata;

    // shift unit
    logic [31:0]                  u_field;
    logic                         u_old;
    logic [WIN_BYTES*8-1:0]       u_new_win;
    logic                         is_write_op;

    bfse_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bfse_shift_unit #(
        .WIN_BYTES (WIN_BYTES)
    ) u_shift (
        .ctl          (ctl_reg),
        .win          (win_reg),
        .insert_value (ival_reg),
        .field_value  (u_field),
        .old_bit      (u_old),
        .new_win      (u_new_win)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Effective size: clamped for field ops, one for bit ops, zero for bad codes.
    always_comb
    begin
        clamp_size = (field_size > 8'(MAX_FIELD_BITS)) ? FSIZE_W'(MAX_FIELD_BITS)
                                                       : FSIZE_W'(field_size);
        case (operation)
            OP_EXT_SIGNED, OP_EXT_UNSIGNED, OP_INSERT: eff_size = clamp_size;
            OP_BIT_SET, OP_BIT_CLEAR:                  eff_size = FSIZE_W'(1);
            default:                                   eff_size = '0;
        endcase
        end_pos = EW'(field_pos) + EW'(eff_size);
        req_oor = (eff_size != '0) && (end_pos > EW'(TOTAL_BITS));
        span    = 7'(field_pos[2:0]) + 7'(eff_size) + 7'd7;
        req_nb  = CW'(span >> 3);
    end

    assign is_write_op = (ctl_reg.op == OP_INSERT) || (ctl_reg.op == OP_BIT_SET)
                      || (ctl_reg.op == OP_BIT_CLEAR);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cnt_next     = cnt_reg;
        nb_next      = nb_reg;
        base_next    = base_reg;
        ctl_next     = ctl_reg;
        ival_next    = ival_reg;
        win_next     = win_reg;
        done_next    = 1'b0;
        fval_next    = fval_reg;
        old_next     = old_reg;
        oor_next     = oor_reg;
        ram_we       = 1'b0;
        ram_addr     = base_reg + AW'(cnt_reg);
        ram_wdata    = win_reg[BW'(cnt_reg)];

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = 8'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctl_next.op     = operation;
                    ctl_next.offset = field_pos[2:0];
                    ctl_next.size   = eff_size;
                    ival_next       = insert_value;
                    base_next       = AW'({{AW{1'b0}}, field_pos[12:3]});
                    nb_next         = req_nb;
                    cnt_next        = '0;
                    win_next        = '0;
                    if (req_oor || (eff_size == '0))
                    begin
                        // nothing to touch: answer at once
                        fval_next  = 32'd0;
                        old_next   = 1'b0;
                        oor_next   = req_oor;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // issue byte cnt, capture byte cnt-1 from the registered read
                if (cnt_reg != '0)
                begin
                    win_next[BW'(cnt_reg - 1'b1)] = ram_rdata;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == nb_reg)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                fval_next = u_field;
                old_next  = u_old;
                oor_next  = 1'b0;
                win_next  = u_new_win;
                cnt_next  = '0;
                if (is_write_op)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_WRITE:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == nb_reg - 1'b1)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        nb_reg   <= nb_next;
        base_reg <= base_next;
        ctl_reg  <= ctl_next;
        ival_reg <= ival_next;
        win_reg  <= win_next;
        fval_reg <= fval_next;
        old_reg  <= old_next;
        oor_reg  <= oor_next;
    end

    assign done         = done_reg;
    assign field_value  = fval_reg;
    assign old_bit      = old_reg;
    assign out_of_range = oor_reg;

endmodule

/* hdl/bfse_ram.sv */
// ----------------------------------------------------------------------------
// bfse_ram - generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module bfse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/bfse_shift_unit.sv */
// ----------------------------------------------------------------------------
// bfse_shift_unit - field shift and merge
// Aligns the gathered byte window by the bit offset: extracts the field
// (sign or zero extended), returns the old bit and builds the merged window.
// ----------------------------------------------------------------------------
module bfse_shift_unit
    import bfse_pkg::*;
#(
    parameter int WIN_BYTES = 5
) (
    input  unit_ctl_t              ctl,
    input  logic [WIN_BYTES*8-1:0] win,
    input  logic [31:0]            insert_value,
    output logic [31:0]            field_value,
    output logic                   old_bit,
    output logic [WIN_BYTES*8-1:0] new_win
);

    localparam int WIN_BITS = WIN_BYTES * 8;

    logic [WIN_BITS-1:0] shifted;
    logic [31:0]         fmask;
    logic [31:0]         raw;
    logic                sbit;
    logic [31:0]         data;
    logic [WIN_BITS-1:0] wmask;
    logic [WIN_BITS-1:0] wdata;
    logic                is_ext;
    logic                is_bit;

    always_comb
    begin
        is_ext  = (ctl.op == OP_EXT_SIGNED) || (ctl.op == OP_EXT_UNSIGNED);
        is_bit  = (ctl.op == OP_BIT_SET) || (ctl.op == OP_BIT_CLEAR);
        shifted = win >> ctl.offset;
        fmask   = (ctl.size >= FSIZE_W'(32)) ? 32'hFFFF_FFFF
                                             : ((32'd1 << ctl.size) - 32'd1);
        raw     = 32'(shifted) & fmask;
        sbit    = raw[5'(ctl.size - 1'b1)];

        field_value = 32'd0;
        if (is_ext)
        begin
            field_value = raw;
            if ((ctl.op == OP_EXT_SIGNED) && (ctl.size != '0) && sbit)
            begin
                field_value = raw | ~fmask;
            end
        end

        old_bit = is_bit & shifted[0];

        // bit ops insert a single constant bit
        if (is_bit)
        begin
            data = (ctl.op == OP_BIT_SET) ? 32'd1 : 32'd0;
        end
        else
        begin
            data = insert_value;
        end
        wmask   = WIN_BITS'(fmask) << ctl.offset;
        wdata   = WIN_BITS'(data & fmask) << ctl.offset;
        new_win = (win & ~wmask) | wdata;
    end

endmodule
